/* src/ffa_pkg.sv */
package ffa_pkg;

    localparam int POOL_BYTES   = 16384;
    localparam int MAX_SEGMENTS = 16;

    localparam int SEG_W  = $clog2(POOL_BYTES);
    localparam int LEN_W  = SEG_W + 1;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int SIZE_W = 15;
    localparam int OFF_W  = 14;
    localparam int CMP_W  = (SIZE_W > LEN_W) ? SIZE_W : LEN_W;
    localparam int OCMP_W = (OFF_W > SEG_W) ? OFF_W : SEG_W;
    localparam int SUM_W  = CMP_W + 1;

    typedef logic [SEG_W-1:0]  seg_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [OFF_W-1:0]  offset_t;

    localparam seg_t POOL_LAST = seg_t'(POOL_BYTES - 1);
    localparam cnt_t CNT_MAX   = cnt_t'(MAX_SEGMENTS);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFIT  = 2'd1,
        STAT_BADOFF = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SPLIT_HI,
        ST_SPLIT_LO,
        ST_MERGE_NEXT,
        ST_SHIFT_DN,
        ST_MERGE_PREV,
        ST_DONE
    } state_t;

    typedef struct packed {
        seg_t lo;
        seg_t hi;
        logic used;
    } seg_entry_t;

    typedef struct packed {
        logic       wr_lo;
        logic       wr_hi;
        logic       wr_used;
        idx_t       idx;
        seg_entry_t data;
    } tbl_wr_t;

    function automatic offset_t to_offset(input seg_t s);
        logic [OCMP_W-1:0] t;
        t = OCMP_W'(s);
        return t[OFF_W-1:0];
    endfunction

endpackage

/* src/ffa_if.sv */
interface ffa_req_if;
    import ffa_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    size_t   request_size;
    offset_t free_offset;

    modport source (output valid, output opcode, output request_size, output free_offset,
                    input ready);
    modport sink (input valid, input opcode, input request_size, input free_offset,
                  output ready);
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    offset_t block_offset;

    modport source (output valid, output status, output block_offset, input ready);
    modport sink (input valid, input status, input block_offset, output ready);
endinterface

/* src/ffa_table.sv */
module ffa_table (
    input  logic                clk,
    input  logic                rst_n,
    input  ffa_pkg::tbl_wr_t    wr,
    input  ffa_pkg::idx_t       rd_idx,
    output ffa_pkg::seg_entry_t rd
);
    import ffa_pkg::*;

    seg_t lo_reg   [MAX_SEGMENTS];
    seg_t hi_reg   [MAX_SEGMENTS];
    logic used_reg [MAX_SEGMENTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                lo_reg[i]   <= '0;
                hi_reg[i]   <= (i == 0) ? POOL_LAST : '0;
                used_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (wr.wr_lo)
            begin
                lo_reg[wr.idx] <= wr.data.lo;
            end
            if (wr.wr_hi)
            begin
                hi_reg[wr.idx] <= wr.data.hi;
            end
            if (wr.wr_used)
            begin
                used_reg[wr.idx] <= wr.data.used;
            end
        end
    end

    always_comb
    begin
        rd.lo   = lo_reg[rd_idx];
        rd.hi   = hi_reg[rd_idx];
        rd.used = used_reg[rd_idx];
    end

endmodule

/* src/ffa_ctrl.sv */
module ffa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    ffa_req_if.sink             req,
    ffa_rsp_if.source           rsp,
    input  ffa_pkg::seg_entry_t rd,
    output ffa_pkg::idx_t       rd_idx,
    output ffa_pkg::tbl_wr_t    wr
);
    import ffa_pkg::*;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    cnt_t    ptr_reg, ptr_next;
    logic    prev_phase_reg, prev_phase_next;
    logic    out_valid_reg, out_valid_next;

    cnt_t    hit_reg, hit_next;
    seg_t    cur_start_reg, cur_start_next;
    seg_t    cur_end_reg, cur_end_next;
    size_t   size_reg, size_next;
    offset_t off_reg, off_next;
    opcode_t op_reg, op_next;
    status_t res_status_reg, res_status_next;
    offset_t res_off_reg, res_off_next;
    status_t out_status_reg, out_status_next;
    offset_t out_off_reg, out_off_next;

    len_t              seg_len;
    logic [SUM_W-1:0]  sum;
    seg_t              split_lo;
    cnt_t              rd_ptr;
    logic fit, exact, match, hit_now, last, full, accept, out_free;
    logic up_more, dn_more, next_free, has_prev;

    // The one shared unit: segment length, size compare, offset compare and split point.
    always_comb
    begin
        seg_len   = LEN_W'(rd.hi) - LEN_W'(rd.lo) + LEN_W'(1);
        fit       = !rd.used && (CMP_W'(size_reg) <= CMP_W'(seg_len));
        exact     = CMP_W'(size_reg) == CMP_W'(seg_len);
        match     = rd.used && (OCMP_W'(rd.lo) == OCMP_W'(off_reg));
        hit_now   = (op_reg == OP_ALLOC) ? fit : match;
        last      = (ptr_reg + cnt_t'(1)) >= count_reg;
        full      = count_reg == CNT_MAX;
        sum       = SUM_W'(cur_start_reg) + SUM_W'(size_reg);
        split_lo  = sum[SEG_W-1:0];
        accept    = req.valid && (state_reg == ST_IDLE);
        out_free  = !out_valid_reg || rsp.ready;
        up_more   = ptr_reg > (hit_reg + cnt_t'(1));
        dn_more   = (ptr_reg + cnt_t'(1)) < count_reg;
        next_free = (ptr_reg < count_reg) && !rd.used;
        has_prev  = hit_reg != '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == OP_ALLOC && req.request_size == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit_now)
                begin
                    if (op_reg == OP_ALLOC)
                        state_next = (exact || full) ? ST_DONE : ST_SHIFT_UP;
                    else
                        state_next = ST_MERGE_NEXT;
                end
                else if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT_UP:
            begin
                if (!up_more)
                    state_next = ST_SPLIT_HI;
            end
            ST_SPLIT_HI:
            begin
                state_next = ST_SPLIT_LO;
            end
            ST_SPLIT_LO:
            begin
                state_next = ST_DONE;
            end
            ST_MERGE_NEXT:
            begin
                if (next_free)
                    state_next = ST_SHIFT_DN;
                else
                    state_next = has_prev ? ST_MERGE_PREV : ST_DONE;
            end
            ST_SHIFT_DN:
            begin
                if (!dn_more)
                    state_next = (!prev_phase_reg && has_prev) ? ST_MERGE_PREV : ST_DONE;
            end
            ST_MERGE_PREV:
            begin
                state_next = rd.used ? ST_DONE : ST_SHIFT_DN;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = state_reg == ST_IDLE;
        rd_ptr    = ptr_reg;
        wr        = '0;
        unique case (state_reg)
            ST_SCAN:
            begin
                if (hit_now && (op_reg == OP_FREE || exact))
                begin
                    wr.wr_used   = 1'b1;
                    wr.idx       = ptr_reg[IDX_W-1:0];
                    wr.data.used = op_reg == OP_ALLOC;
                end
            end
            ST_SHIFT_UP:
            begin
                rd_ptr = ptr_reg - cnt_t'(1);
                if (up_more)
                begin
                    wr.wr_lo   = 1'b1;
                    wr.wr_hi   = 1'b1;
                    wr.wr_used = 1'b1;
                    wr.idx     = ptr_reg[IDX_W-1:0];
                    wr.data    = rd;
                end
            end
            ST_SPLIT_HI:
            begin
                wr.wr_lo     = 1'b1;
                wr.wr_hi     = 1'b1;
                wr.wr_used   = 1'b1;
                wr.idx       = idx_t'(hit_reg + cnt_t'(1));
                wr.data.lo   = split_lo;
                wr.data.hi   = cur_end_reg;
                wr.data.used = 1'b0;
            end
            ST_SPLIT_LO:
            begin
                wr.wr_hi     = 1'b1;
                wr.wr_used   = 1'b1;
                wr.idx       = hit_reg[IDX_W-1:0];
                wr.data.hi   = split_lo - seg_t'(1);
                wr.data.used = 1'b1;
            end
            ST_MERGE_NEXT:
            begin
                if (next_free)
                begin
                    wr.wr_hi   = 1'b1;
                    wr.idx     = hit_reg[IDX_W-1:0];
                    wr.data.hi = rd.hi;
                end
            end
            ST_SHIFT_DN:
            begin
                rd_ptr = ptr_reg + cnt_t'(1);
                if (dn_more)
                begin
                    wr.wr_lo   = 1'b1;
                    wr.wr_hi   = 1'b1;
                    wr.wr_used = 1'b1;
                    wr.idx     = ptr_reg[IDX_W-1:0];
                    wr.data    = rd;
                end
            end
            ST_MERGE_PREV:
            begin
                if (!rd.used)
                begin
                    wr.wr_hi   = 1'b1;
                    wr.idx     = ptr_reg[IDX_W-1:0];
                    wr.data.hi = cur_end_reg;
                end
            end
            ST_IDLE, ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        rd_idx = rd_ptr[IDX_W-1:0];

        rsp.valid        = out_valid_reg;
        rsp.status       = out_status_reg;
        rsp.block_offset = out_off_reg;
    end

    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        prev_phase_next = prev_phase_reg;
        hit_next        = hit_reg;
        cur_start_next  = cur_start_reg;
        cur_end_next    = cur_end_reg;
        size_next       = size_reg;
        off_next        = off_reg;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        out_status_next = out_status_reg;
        out_off_next    = out_off_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.opcode;
                    size_next       = req.request_size;
                    off_next        = req.free_offset;
                    ptr_next        = '0;
                    res_status_next = STAT_NOFIT;
                    res_off_next    = '0;
                end
            end
            ST_SCAN:
            begin
                if (hit_now)
                begin
                    hit_next       = ptr_reg;
                    cur_start_next = rd.lo;
                    cur_end_next   = rd.hi;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (exact)
                        begin
                            res_status_next = STAT_OK;
                            res_off_next    = to_offset(rd.lo);
                        end
                        else if (full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ptr_next = count_reg;
                        end
                    end
                    else
                    begin
                        res_status_next = STAT_OK;
                        res_off_next    = off_reg;
                        ptr_next        = ptr_reg + cnt_t'(1);
                    end
                end
                else if (last)
                begin
                    res_status_next = (op_reg == OP_ALLOC) ? STAT_NOFIT : STAT_BADOFF;
                end
                else
                begin
                    ptr_next = ptr_reg + cnt_t'(1);
                end
            end
            ST_SHIFT_UP:
            begin
                if (up_more)
                    ptr_next = ptr_reg - cnt_t'(1);
            end
            ST_SPLIT_HI:
            begin
                count_next = count_reg + cnt_t'(1);
            end
            ST_SPLIT_LO:
            begin
                res_status_next = STAT_OK;
                res_off_next    = to_offset(cur_start_reg);
            end
            ST_MERGE_NEXT:
            begin
                if (next_free)
                begin
                    cur_end_next    = rd.hi;
                    prev_phase_next = 1'b0;
                end
                else if (has_prev)
                begin
                    ptr_next = hit_reg - cnt_t'(1);
                end
            end
            ST_SHIFT_DN:
            begin
                if (dn_more)
                begin
                    ptr_next = ptr_reg + cnt_t'(1);
                end
                else
                begin
                    count_next = count_reg - cnt_t'(1);
                    if (!prev_phase_reg && has_prev)
                        ptr_next = hit_reg - cnt_t'(1);
                end
            end
            ST_MERGE_PREV:
            begin
                if (!rd.used)
                begin
                    ptr_next        = hit_reg;
                    prev_phase_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_off_next    = res_off_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= cnt_t'(1);
            ptr_reg        <= '0;
            prev_phase_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            prev_phase_reg <= prev_phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        cur_start_reg  <= cur_start_next;
        cur_end_reg    <= cur_end_next;
        size_reg       <= size_next;
        off_reg        <= off_next;
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        out_status_reg <= out_status_next;
        out_off_reg    <= out_off_next;
    end

    // The table always holds at least one segment and never more than it has room for.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_MAX))
        else $error("segment count out of range");

    // The segment count changes by at most one per step; a free that merges twice removes two.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + cnt_t'(1)) ||
         (count_reg == $past(count_reg) - cnt_t'(1))))
        else $error("segment count jumped");

    // A split is only started when a free table entry exists.
    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT_HI) |-> (count_reg < CNT_MAX))
        else $error("split with a full table");

    // An error result always reports offset zero.
    a_err_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STAT_OK) |-> (out_off_reg == '0))
        else $error("error result with nonzero offset");

    // An accepted item always starts work on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item was not started");

endmodule

/* src/first_fit_allocator.sv */
// First-fit pool allocator over a table of address-ordered segments. An allocate item takes the
// lowest free segment that is large enough and returns its start offset; a free item releases
// the used segment starting at the given offset and merges it with free neighbors. One item is
// worked on at a time and req.ready is low until it is finished. The segment table has a single
// read port, so the sequencer scans one entry per cycle until a hit or the last entry. A split
// then moves the later entries up one at a time and writes the two halves. A free looks at the
// next segment and, unless it freed the first entry, at the previous one; each merge moves the
// later entries down one at a time. Results are held in an output register, so the next item is
// taken while a result waits on rsp; an item that finishes while the previous result still
// waits holds in its done state until rsp takes that result.
module first_fit_allocator (
    input  logic      clk,
    input  logic      rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp
);
    import ffa_pkg::*;

    idx_t       rd_idx;
    seg_entry_t rd;
    tbl_wr_t    wr;

    ffa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .rd     (rd),
        .rd_idx (rd_idx),
        .wr     (wr)
    );

    ffa_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_idx (rd_idx),
        .rd     (rd)
    );

endmodule

/* test/first_fit_allocator_checker.sv */
`timescale 1ns / 100ps

module first_fit_allocator_checker (
    input  logic clk,
    input  logic rst_n,
    ffa_req_if   req,
    ffa_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);
    import ffa_pkg::*;

    typedef struct {
        status_t st;
        offset_t off;
    } outcome_t;

    int unsigned pool_lo[MAX_SEGMENTS];
    int unsigned pool_hi[MAX_SEGMENTS];
    bit          pool_used[MAX_SEGMENTS];
    int          pool_count;
    outcome_t    outcomes_due[$];

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    task automatic reset_pool();
        int k;
        for (k = 0; k < MAX_SEGMENTS; k++)
        begin
            pool_lo[k] = 0;
            pool_hi[k] = 0;
            pool_used[k] = 1'b0;
        end
        pool_hi[0] = POOL_BYTES - 1;
        pool_count = 1;
    endtask

    task automatic drop_segment(input int k);
        int j;
        for (j = k; j + 1 < pool_count; j++)
        begin
            pool_lo[j] = pool_lo[j + 1];
            pool_hi[j] = pool_hi[j + 1];
            pool_used[j] = pool_used[j + 1];
        end
        pool_count--;
    endtask

    task automatic pool_alloc(input int unsigned want, output status_t st,
                              output int unsigned where);
        int          k;
        int          hit;
        int unsigned len;
        st = STAT_NOFIT;
        where = 0;
        hit = -1;
        if (want == 0)
            return;
        for (k = 0; k < pool_count; k++)
        begin
            len = pool_hi[k] - pool_lo[k] + 1;
            if (!pool_used[k] && want <= len)
            begin
                hit = k;
                break;
            end
        end
        if (hit < 0)
            return;
        len = pool_hi[hit] - pool_lo[hit] + 1;
        if (want < len)
        begin
            if (pool_count >= MAX_SEGMENTS)
            begin
                st = STAT_FULL;
                return;
            end
            for (k = pool_count; k > hit + 1; k--)
            begin
                pool_lo[k] = pool_lo[k - 1];
                pool_hi[k] = pool_hi[k - 1];
                pool_used[k] = pool_used[k - 1];
            end
            pool_lo[hit + 1] = pool_lo[hit] + want;
            pool_hi[hit + 1] = pool_hi[hit];
            pool_used[hit + 1] = 1'b0;
            pool_hi[hit] = pool_lo[hit] + want - 1;
            pool_count++;
        end
        pool_used[hit] = 1'b1;
        where = pool_lo[hit];
        st = STAT_OK;
    endtask

    task automatic pool_free(input int unsigned off, output status_t st,
                             output int unsigned where);
        int k;
        int hit;
        st = STAT_BADOFF;
        where = 0;
        hit = -1;
        for (k = 0; k < pool_count; k++)
        begin
            if (pool_used[k] && pool_lo[k] == off)
            begin
                hit = k;
                break;
            end
        end
        if (hit < 0)
            return;
        pool_used[hit] = 1'b0;
        if (hit + 1 < pool_count && !pool_used[hit + 1])
        begin
            pool_hi[hit] = pool_hi[hit + 1];
            drop_segment(hit + 1);
        end
        if (hit > 0 && !pool_used[hit - 1])
        begin
            pool_hi[hit - 1] = pool_hi[hit];
            drop_segment(hit);
        end
        where = off;
        st = STAT_OK;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t    want;
        status_t     st;
        int unsigned where;
        if (!rst_n)
        begin
            reset_pool();
            outcomes_due.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: unexpected item status %s offset %0d", $time,
                             rsp.status.name(), rsp.block_offset);
                    fail_count++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (rsp.status !== want.st)
                    begin
                        $display("%0t: status expected %s actual %s", $time,
                                 want.st.name(), rsp.status.name());
                        fail_count++;
                    end
                    if (rsp.block_offset !== want.off)
                    begin
                        $display("%0t: block_offset expected %0d actual %0d", $time,
                                 want.off, rsp.block_offset);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.opcode == OP_ALLOC)
                    pool_alloc(req.request_size, st, where);
                else
                    pool_free(req.free_offset, st, where);
                want.st = st;
                want.off = (st == STAT_OK) ? offset_t'(where) : '0;
                outcomes_due.push_back(want);
            end
            pending <= outcomes_due.size();
        end
    end

endmodule

/* test/first_fit_allocator_tb.sv */
`timescale 1ns / 100ps

module first_fit_allocator_tb;
    import ffa_pkg::*;

    localparam int ITEMS          = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 3 * MAX_SEGMENTS + 16;

    typedef struct {
        opcode_t op;
        int      len;
    } issued_t;

    typedef struct {
        offset_t off;
        int      len;
    } held_t;

    logic    clk;
    logic    rst_n;
    bit      idle_on;
    int      fail_count;
    int      pending;
    int      quiet_cycles;
    int      freed_len;
    offset_t freed_off;
    issued_t issued[$];
    held_t   held[$];

    ffa_req_if req();
    ffa_rsp_if rsp();

    first_fit_allocator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    first_fit_allocator_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Track which offsets are live so that most frees name a real allocation.
    always @(posedge clk)
    begin
        issued_t sent;
        int      k;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready && issued.size() > 0)
            begin
                sent = issued.pop_front();
                if (rsp.status == STAT_OK && sent.op == OP_ALLOC)
                    held.push_back('{rsp.block_offset, sent.len});
                else if (rsp.status == STAT_OK)
                begin
                    for (k = 0; k < held.size(); k++)
                    begin
                        if (held[k].off == rsp.block_offset)
                        begin
                            held.delete(k);
                            break;
                        end
                    end
                end
            end
            if (req.valid && req.ready)
                issued.push_back('{req.opcode, int'(req.request_size)});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("first_fit_allocator_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic issue(input opcode_t op, input int len, input offset_t off);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.request_size <= size_t'(len);
        req.free_offset <= off;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic random_item();
        int    r;
        int    k;
        int    len;
        held_t h;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            if ($urandom_range(0, 1) == 1)
                issue(OP_FREE, $urandom, freed_off);
            else
                issue(OP_FREE, $urandom, offset_t'($urandom));
        end
        else if (held.size() > 0 && r < ((held.size() >= 12) ? 75 : 40))
        begin
            k = $urandom_range(0, held.size() - 1);
            h = held[k];
            held.delete(k);
            freed_len = h.len;
            freed_off = h.off;
            issue(OP_FREE, $urandom, h.off);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                len = 0;
            else if (r < 6)
                len = $urandom_range(POOL_BYTES, (1 << SIZE_W) - 1);
            else if (r < 18 && freed_len > 0)
                len = freed_len;
            else if (r < 70)
                len = $urandom_range(1, 64);
            else if (r < 92)
                len = $urandom_range(1, 1024);
            else
                len = $urandom_range(1, POOL_BYTES);
            issue(OP_ALLOC, len, offset_t'($urandom));
        end
    endtask

    initial
    begin
        int i;
        int k;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.opcode <= OP_ALLOC;
        req.request_size <= '0;
        req.free_offset <= '0;
        idle_on = 1'b1;
        quiet_cycles = 0;
        freed_len = 0;
        freed_off = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Freeing a free segment, zero and oversized requests, whole pool taken.
        issue(OP_FREE, $urandom, offset_t'(0));
        issue(OP_ALLOC, 0, offset_t'($urandom));
        issue(OP_ALLOC, (1 << SIZE_W) - 1, offset_t'($urandom));
        issue(OP_ALLOC, POOL_BYTES + 1, offset_t'($urandom));
        issue(OP_ALLOC, POOL_BYTES, offset_t'($urandom));
        issue(OP_FREE, $urandom, offset_t'(POOL_BYTES - 1));
        issue(OP_FREE, $urandom, offset_t'(0));

        // Fill the table, hit the full case, then take the rest with an exact fit.
        for (k = 0; k < MAX_SEGMENTS - 1; k++)
            issue(OP_ALLOC, 1, offset_t'($urandom));
        issue(OP_ALLOC, 1, offset_t'($urandom));
        issue(OP_ALLOC, POOL_BYTES - (MAX_SEGMENTS - 1), offset_t'($urandom));

        // Free isolated blocks, then the one between them to merge on both sides.
        issue(OP_FREE, $urandom, offset_t'(5));
        issue(OP_FREE, $urandom, offset_t'(7));
        issue(OP_FREE, $urandom, offset_t'(6));

        for (i = 0; i < ITEMS; i++)
        begin
            if (i == ITEMS / 2)
            begin
                req.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            idle_on = !((i >= 150 && i < 220) || i >= ITEMS - 100);
            random_item();
        end
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("first_fit_allocator_tb passed");
        else
            $display("first_fit_allocator_tb failed");
        $finish;
    end

endmodule

/* sim.f */
src/ffa_pkg.sv
src/ffa_if.sv
src/ffa_table.sv
src/ffa_ctrl.sv
src/first_fit_allocator.sv
test/first_fit_allocator_checker.sv
test/first_fit_allocator_tb.sv
